### rtl/sgt_pkg.sv
package sgt_pkg;

    localparam int PIX_W      = 8;
    localparam int SAT_W      = 8;
    localparam int BOOST_W    = 8;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIX_W-1:0]   PIX_MAX    = 8'hFF;
    localparam logic [SAT_W-1:0]   SAT_RST    = 8'd16;
    localparam logic [BOOST_W-1:0] BOOST_RST  = 8'd4;
    localparam logic [IW_W-1:0]    WIDTH_RST  = 11'd640;
    localparam logic [IH_W-1:0]    HEIGHT_RST = 13'd480;
    localparam logic [IW_W-1:0]    MIN_WIDTH  = 11'd3;
    localparam logic [IH_W-1:0]    MIN_HEIGHT = 13'd2;

    // output queue; credits keep it from overflowing
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SATURATION = 2'd0,
        CFG_BOOST      = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_HEIGHT     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] grad_x;
        logic [PIX_W-1:0] grad_y;
        logic             line_end;
        logic             frame_end;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### rtl/sgt_line_cell.sv
module sgt_line_cell #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [sgt_pkg::PIX_W-1:0]  wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [sgt_pkg::PIX_W-1:0]  rdata
);

    logic [sgt_pkg::PIX_W-1:0] line_mem [DEPTH];
    logic [sgt_pkg::PIX_W-1:0] rdata_reg;

    // read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= line_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sgt_boost.sv
module sgt_boost (
    input  logic                         clk,
    input  logic [sgt_pkg::PIX_W-1:0]    a,
    input  logic [sgt_pkg::PIX_W-1:0]    b,
    input  logic [sgt_pkg::SAT_W-1:0]    saturation,
    input  logic [sgt_pkg::BOOST_W-1:0]  boost,
    output logic [sgt_pkg::PIX_W-1:0]    grad
);

    logic signed [9:0]          sat_s;
    logic signed [9:0]          diff;
    logic signed [9:0]          clamped;
    logic signed [9:0]          sum;
    logic [8:0]                 sum_next;
    logic [8:0]                 sum_reg;
    logic [16:0]                product;
    logic [sgt_pkg::PIX_W-1:0]  grad_next;
    logic [sgt_pkg::PIX_W-1:0]  grad_reg;

    always_comb
    begin
        sat_s    = $signed({2'b00, saturation});
        diff     = $signed({2'b00, b}) - $signed({2'b00, a});
        clamped  = (diff > sat_s) ? sat_s : diff;
        sum      = sat_s + clamped;
        sum_next = sum[9] ? '0 : sum[8:0];
    end

    always_comb
    begin
        product   = 17'(sum_reg) * 17'(boost);
        grad_next = (product > 17'(sgt_pkg::PIX_MAX)) ? sgt_pkg::PIX_MAX : product[7:0];
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        grad_reg <= grad_next;
    end

    assign grad = grad_reg;

endmodule

### rtl/sgt_out_fifo.sv
module sgt_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sgt_pkg::result_t    push_word,
    input  logic                pop,
    output sgt_pkg::result_t    head,
    output sgt_pkg::fifo_stat_t stat
);

    localparam int AW = sgt_pkg::FIFO_AW;

    sgt_pkg::result_t entries_reg [sgt_pkg::FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (AW+1)'(sgt_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

### rtl/saturated_gradient_texture_core.sv
// Saturated central-difference gradient over a raster pixel stream.
// Input channel (in_valid/in_ready): one word per pixel, raster order. With
// drain high a word is a drain request; drains count only after the last row
// of the frame has been taken, pixels sent then are dropped.
// Output channel (out_valid/out_ready): grad_x, grad_y, line_end, frame_end.
// The first input row yields nothing; each later pixel yields the result of
// the pixel one row above. After the frame, image_width drain words give the
// all-zero final row, frame_end on its last word.
// Config port (cfg_we/cfg_index/cfg_data): write while the block is idle.
// Timing: a result passes the stage registers and output queue; one word per
// cycle is taken while in_ready is high. The line buffers are a chain of two
// single-port-read cells; the gradient runs in a two-stage boost pipe.
// A credit count over an 8-entry output queue drops in_ready when 8 results
// are outstanding, so a stalled receiver holds the input without loss.
// Reset clears the counters and the queue and loads default registers; line
// buffers are not cleared, the first rows of a frame do not depend on them.
module saturated_gradient_texture_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sgt_pkg::PIX_W-1:0]         pixel,
    input  logic                              drain,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sgt_pkg::PIX_W-1:0]         grad_x,
    output logic [sgt_pkg::PIX_W-1:0]         grad_y,
    output logic                              line_end,
    output logic                              frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = sgt_pkg::FIFO_AW + 1;

    // config registers
    logic [sgt_pkg::SAT_W-1:0]   sat_reg;
    logic [sgt_pkg::BOOST_W-1:0] boost_reg;
    logic [sgt_pkg::IW_W-1:0]    width_reg;
    logic [sgt_pkg::IH_W-1:0]    height_reg;

    // frame position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             draining_reg;
    logic             draining_next;

    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic             col_last;
    logic             row_last;
    logic             acc;
    logic             acc_pix;
    logic             acc_drain;
    logic             acc_emit;
    logic [COL_W-1:0] ahead_addr;

    // stage 1
    logic                      s1_pix_reg;
    logic                      s1_emit_reg;
    logic                      s1_zero_reg;
    logic                      s1_zero_next;
    logic                      s1_le_reg;
    logic                      s1_fe_reg;
    logic [sgt_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [sgt_pkg::PIX_W-1:0] right_rd;
    logic [sgt_pkg::PIX_W-1:0] prev_reg;
    logic [sgt_pkg::PIX_W-1:0] left_reg;

    // stage 2
    logic                      s2_emit_reg;
    logic                      s2_zero_reg;
    logic                      s2_le_reg;
    logic                      s2_fe_reg;
    logic [sgt_pkg::PIX_W-1:0] s2_left_reg;
    logic [sgt_pkg::PIX_W-1:0] s2_right_reg;
    logic [sgt_pkg::PIX_W-1:0] s2_below_reg;
    logic [sgt_pkg::PIX_W-1:0] above2_rd;

    // stages 3 and 4 track the boost pipe
    logic                      s3_emit_reg;
    logic                      s3_zero_reg;
    logic                      s3_le_reg;
    logic                      s3_fe_reg;
    logic                      s4_emit_reg;
    logic                      s4_zero_reg;
    logic                      s4_le_reg;
    logic                      s4_fe_reg;
    logic [sgt_pkg::PIX_W-1:0] gx;
    logic [sgt_pkg::PIX_W-1:0] gy;

    sgt_pkg::result_t    push_word;
    sgt_pkg::result_t    head;
    sgt_pkg::fifo_stat_t fifo_stat;
    logic                fifo_pop;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg    <= sgt_pkg::SAT_RST;
            boost_reg  <= sgt_pkg::BOOST_RST;
            width_reg  <= sgt_pkg::WIDTH_RST;
            height_reg <= sgt_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (sgt_pkg::cfg_idx_t'(cfg_index))
                sgt_pkg::CFG_SATURATION: sat_reg    <= cfg_data[sgt_pkg::SAT_W-1:0];
                sgt_pkg::CFG_BOOST:      boost_reg  <= cfg_data[sgt_pkg::BOOST_W-1:0];
                sgt_pkg::CFG_WIDTH:      width_reg  <= cfg_data[sgt_pkg::IW_W-1:0];
                sgt_pkg::CFG_HEIGHT:     height_reg <= cfg_data[sgt_pkg::IH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < sgt_pkg::MIN_WIDTH)
        begin
            eff_w = WW'(sgt_pkg::MIN_WIDTH);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (height_reg < sgt_pkg::MIN_HEIGHT)
        begin
            eff_h = HW'(sgt_pkg::MIN_HEIGHT);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(height_reg);
        end
    end

    // ---------------- input side ----------------
    assign in_ready = (cnt_reg != CNT_W'(sgt_pkg::FIFO_DEPTH));
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        col_last  = (WW'(col_reg) + WW'(1)) >= eff_w;
        row_last  = (HW'(row_reg) + HW'(1)) >= eff_h;
        acc_pix   = acc && !draining_reg && !drain;
        acc_drain = acc && draining_reg && drain;
        acc_emit  = acc_drain || (acc_pix && (row_reg != '0));
        // the last column's right neighbor is never used, so prefetch column 0
        ahead_addr = col_last ? '0 : col_reg + COL_W'(1);

        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (acc_pix || acc_drain)
        begin
            col_next = col_last ? '0 : col_reg + COL_W'(1);
        end
        if (acc_drain && col_last)
        begin
            row_next      = '0;
            draining_next = 1'b0;
        end
        if (acc_pix && col_last)
        begin
            if (row_last)
            begin
                row_next      = '0;
                draining_next = 1'b1;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end

        s1_zero_next = draining_reg || (row_reg == ROW_W'(1)) || (col_reg == '0) || col_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
            s1_pix_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_emit_reg  <= 1'b0;
            s3_emit_reg  <= 1'b0;
            s4_emit_reg  <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
            s1_pix_reg   <= acc_pix;
            s1_emit_reg  <= acc_emit;
            s2_emit_reg  <= s1_emit_reg;
            s3_emit_reg  <= s2_emit_reg;
            s4_emit_reg  <= s3_emit_reg;
            cnt_reg      <= cnt_next;
        end
    end

    // previous row: written with the new pixel, read one column ahead
    sgt_line_cell #(
        .DEPTH (MAX_WIDTH)
    ) u_cell_above (
        .clk   (clk),
        .we    (acc_pix),
        .waddr (col_reg),
        .wdata (pixel),
        .re    (acc_pix),
        .raddr (ahead_addr),
        .rdata (right_rd)
    );

    // ---------------- stage 1 ----------------
    // prev_reg is the center of the row above (fetched as the last item's right)
    always_ff @(posedge clk)
    begin
        s1_zero_reg  <= s1_zero_next;
        s1_le_reg    <= col_last;
        s1_fe_reg    <= draining_reg && col_last;
        s1_pixel_reg <= pixel;
        s1_col_reg   <= col_reg;

        if (s1_pix_reg)
        begin
            prev_reg <= right_rd;
            left_reg <= prev_reg;
        end

        s2_zero_reg  <= s1_zero_reg;
        s2_le_reg    <= s1_le_reg;
        s2_fe_reg    <= s1_fe_reg;
        s2_left_reg  <= left_reg;
        s2_right_reg <= right_rd;
        s2_below_reg <= s1_pixel_reg;

        s3_zero_reg  <= s2_zero_reg;
        s3_le_reg    <= s2_le_reg;
        s3_fe_reg    <= s2_fe_reg;
        s4_zero_reg  <= s3_zero_reg;
        s4_le_reg    <= s3_le_reg;
        s4_fe_reg    <= s3_fe_reg;
    end

    // row two above: takes the word handed down from the first cell
    sgt_line_cell #(
        .DEPTH (MAX_WIDTH)
    ) u_cell_above2 (
        .clk   (clk),
        .we    (s1_pix_reg),
        .waddr (s1_col_reg),
        .wdata (prev_reg),
        .re    (s1_pix_reg),
        .raddr (s1_col_reg),
        .rdata (above2_rd)
    );

    // ---------------- stages 2 to 4 ----------------
    sgt_boost u_boost_x (
        .clk        (clk),
        .a          (s2_left_reg),
        .b          (s2_right_reg),
        .saturation (sat_reg),
        .boost      (boost_reg),
        .grad       (gx)
    );

    sgt_boost u_boost_y (
        .clk        (clk),
        .a          (above2_rd),
        .b          (s2_below_reg),
        .saturation (sat_reg),
        .boost      (boost_reg),
        .grad       (gy)
    );

    always_comb
    begin
        push_word.grad_x    = s4_zero_reg ? '0 : gx;
        push_word.grad_y    = s4_zero_reg ? '0 : gy;
        push_word.line_end  = s4_le_reg;
        push_word.frame_end = s4_fe_reg;
    end

    // ---------------- output side ----------------
    sgt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_emit_reg),
        .push_word (push_word),
        .pop       (fifo_pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    assign out_valid = !fifo_stat.empty;
    assign fifo_pop  = out_valid && out_ready;
    assign grad_x    = head.grad_x;
    assign grad_y    = head.grad_y;
    assign line_end  = head.line_end;
    assign frame_end = head.frame_end;

    // credits: results promised at accept and not yet taken
    assign cnt_next = cnt_reg + CNT_W'(acc_emit) - CNT_W'(fifo_pop);

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(sgt_pkg::FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s4_emit_reg |-> !fifo_stat.full)
        else $error("push into full output queue");

    a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (row_reg == '0))
        else $error("row count not cleared while draining");

    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> line_end)
        else $error("frame end without line end");

    a_valid_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != '0))
        else $error("queued word without credit");
`endif

endmodule
